// ===== src/fdsc_pkg.sv =====
// Shared types, constants and membership tables for the fuzzy distance-to-speed controller.
// Used by fdsc_sweep, fdsc_div and the top level; no dependencies.
`timescale 1ns / 1ps
package fdsc_pkg;

  localparam int N_DIST_TERMS  = 4;
  localparam int N_SPEED_TERMS = 6;
  localparam int MEMB_BITS     = 8;
  localparam int MEMB_W        = MEMB_BITS + 1;
  localparam int ONE           = 1 << MEMB_BITS;
  localparam int TERM_BITS     = $clog2(N_DIST_TERMS);
  localparam int RULE_BITS     = 3 * TERM_BITS;
  localparam int N_RULES       = 1 << RULE_BITS;
  localparam int SPD_IDX_BITS  = $clog2(N_SPEED_TERMS);

  localparam int SWEEP_LO  = -200;
  localparam int SWEEP_HI  = 150;
  localparam int X_W       = 9;
  localparam int R_W       = 8;
  localparam int AREA_BITS = 18;
  localparam int MOM_BITS  = 28;
  localparam int DIVN_BITS = MOM_BITS + 1;
  localparam int DIVD_BITS = AREA_BITS + 1;

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FLOOR   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CEILING = 2'd1;
  localparam logic signed [15:0] FLOOR_RESET   = 16'sd0;
  localparam logic signed [15:0] CEILING_RESET = 16'sd255;

  typedef logic [MEMB_W-1:0] memb_t;

  typedef enum logic [2:0] {
    S_IDLE, S_FUZZ, S_RULE, S_SWEEP_GO, S_SWEEP, S_DIV_GO, S_DIV, S_DONE
  } st_t;

  typedef struct packed {
    logic                        done;
    logic [AREA_BITS-1:0]        area;
    logic signed [MOM_BITS-1:0]  moment;
  } sweep_res_t;

  typedef struct packed {
    logic                 done;
    logic [DIVN_BITS-1:0] quot;
  } div_res_t;

  // Distance terms: every slope spans DIST_SLOPE units.
  localparam int DIST_A [N_DIST_TERMS] = '{-15, 10, 35, 60};
  localparam int DIST_B [N_DIST_TERMS] = '{0, 25, 50, 75};
  localparam int DIST_C [N_DIST_TERMS] = '{10, 35, 60, 255};
  localparam int DIST_D [N_DIST_TERMS] = '{25, 50, 75, 270};
  localparam int DIST_SLOPE  = 15;
  localparam int DIST_N_BITS = $clog2(DIST_SLOPE);
  localparam int DIST_RECIP  = ((ONE << 8) / DIST_SLOPE) + 1;

  localparam int SPD_A [N_SPEED_TERMS] = '{-200, -135, -115, 40, 50, 65};
  localparam int SPD_B [N_SPEED_TERMS] = '{-175, -115, -85, 45, 55, 95};
  localparam int SPD_C [N_SPEED_TERMS] = '{-135, -105, -70, 50, 65, 125};
  localparam int SPD_D [N_SPEED_TERMS] = '{-105, -85, -60, 55, 95, 150};

  localparam int RISE_WD [N_SPEED_TERMS] = '{
    SPD_B[0] - SPD_A[0], SPD_B[1] - SPD_A[1], SPD_B[2] - SPD_A[2],
    SPD_B[3] - SPD_A[3], SPD_B[4] - SPD_A[4], SPD_B[5] - SPD_A[5]};
  localparam int FALL_WD [N_SPEED_TERMS] = '{
    SPD_D[0] - SPD_C[0], SPD_D[1] - SPD_C[1], SPD_D[2] - SPD_C[2],
    SPD_D[3] - SPD_C[3], SPD_D[4] - SPD_C[4], SPD_D[5] - SPD_C[5]};
  localparam int RISE_Q [N_SPEED_TERMS] = '{
    ONE / RISE_WD[0], ONE / RISE_WD[1], ONE / RISE_WD[2],
    ONE / RISE_WD[3], ONE / RISE_WD[4], ONE / RISE_WD[5]};
  localparam int RISE_R [N_SPEED_TERMS] = '{
    ONE % RISE_WD[0], ONE % RISE_WD[1], ONE % RISE_WD[2],
    ONE % RISE_WD[3], ONE % RISE_WD[4], ONE % RISE_WD[5]};
  localparam int FALL_Q [N_SPEED_TERMS] = '{
    ONE / FALL_WD[0], ONE / FALL_WD[1], ONE / FALL_WD[2],
    ONE / FALL_WD[3], ONE / FALL_WD[4], ONE / FALL_WD[5]};
  localparam int FALL_R [N_SPEED_TERMS] = '{
    ONE % FALL_WD[0], ONE % FALL_WD[1], ONE % FALL_WD[2],
    ONE % FALL_WD[3], ONE % FALL_WD[4], ONE % FALL_WD[5]};

  // Rule tables, index = left*16 + mid*4 + right.
  localparam logic [SPD_IDX_BITS-1:0] RULE_LEFT [N_RULES] = '{
    3'd1, 3'd3, 3'd5, 3'd4, 3'd1, 3'd3, 3'd5, 3'd4,
    3'd1, 3'd3, 3'd5, 3'd4, 3'd1, 3'd3, 3'd5, 3'd4,
    3'd4, 3'd1, 3'd4, 3'd1, 3'd4, 3'd1, 3'd4, 3'd5,
    3'd1, 3'd1, 3'd1, 3'd5, 3'd4, 3'd1, 3'd5, 3'd5,
    3'd1, 3'd1, 3'd3, 3'd1, 3'd1, 3'd2, 3'd3, 3'd5,
    3'd1, 3'd2, 3'd3, 3'd5, 3'd1, 3'd1, 3'd4, 3'd5,
    3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd3, 3'd4, 3'd3,
    3'd1, 3'd3, 3'd4, 3'd4, 3'd1, 3'd3, 3'd4, 3'd5};
  localparam logic [SPD_IDX_BITS-1:0] RULE_RIGHT [N_RULES] = '{
    3'd4, 3'd2, 3'd3, 3'd1, 3'd4, 3'd2, 3'd3, 3'd1,
    3'd4, 3'd2, 3'd3, 3'd1, 3'd4, 3'd2, 3'd3, 3'd1,
    3'd1, 3'd4, 3'd1, 3'd4, 3'd1, 3'd4, 3'd1, 3'd3,
    3'd1, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd3,
    3'd4, 3'd4, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5, 3'd3,
    3'd4, 3'd3, 3'd5, 3'd4, 3'd4, 3'd4, 3'd5, 3'd4,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5,
    3'd4, 3'd5, 3'd5, 3'd5, 3'd4, 3'd5, 3'd5, 3'd5};

  function automatic memb_t dist_grade(input int t, input logic signed [15:0] x);
    logic [DIST_N_BITS-1:0] n;
    logic [31:0]            prod;
    memb_t                  g;
    n    = '0;
    g    = '0;
    if (x <= DIST_A[t] || x >= DIST_D[t]) begin
      g = '0;
    end else if (x < DIST_B[t]) begin
      n    = DIST_N_BITS'(x - DIST_A[t]);
      prod = 32'(n) * 32'(DIST_RECIP);
      g    = MEMB_W'(prod >> 8);
    end else if (x <= DIST_C[t]) begin
      g = MEMB_W'(ONE);
    end else begin
      n    = DIST_N_BITS'(DIST_D[t] - x);
      prod = 32'(n) * 32'(DIST_RECIP);
      g    = MEMB_W'(prod >> 8);
    end
    return g;
  endfunction

endpackage

// ===== src/fdsc_sweep.sv =====
// Speed-universe sweep: per-term incremental slope lanes, clip, max and area/moment sums.
// Depends on fdsc_pkg.
`timescale 1ns / 1ps
module fdsc_sweep (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  fdsc_pkg::memb_t      strength [fdsc_pkg::N_SPEED_TERMS],
  output fdsc_pkg::sweep_res_t res
);
  localparam int N  = fdsc_pkg::N_SPEED_TERMS;
  localparam int XW = fdsc_pkg::X_W;
  localparam int RW = fdsc_pkg::R_W;
  localparam int MW = fdsc_pkg::MEMB_W;

  logic                  run;
  logic signed [XW-1:0]  x;
  logic signed [XW-1:0]  xn;
  fdsc_pkg::memb_t       q [N];
  logic signed [RW-1:0]  r [N];
  fdsc_pkg::memb_t       q_next [N];
  logic signed [RW-1:0]  r_next [N];
  fdsc_pkg::memb_t       gc [N];
  fdsc_pkg::memb_t       agg;
  fdsc_pkg::memb_t       agg_r;
  logic signed [XW-1:0]  xa_r;
  logic                  agg_v;
  logic                  last_v;
  logic                  done;
  logic [fdsc_pkg::AREA_BITS-1:0]       area;
  logic signed [fdsc_pkg::MOM_BITS-1:0] moment;
  logic signed [MW+XW:0] prod;

  assign xn = x + XW'(1);

  for (genvar t = 0; t < N; t++) begin : g_lane
    fdsc_pkg::memb_t      g;
    fdsc_pkg::memb_t      q_up;
    fdsc_pkg::memb_t      q_dn;
    logic signed [RW-1:0] r_up;
    logic signed [RW-1:0] r_dn;

    always_comb begin
      if (x >= fdsc_pkg::SPD_B[t] && x <= fdsc_pkg::SPD_C[t]) begin
        g = MW'(fdsc_pkg::ONE);
      end else if (x > fdsc_pkg::SPD_A[t] && x < fdsc_pkg::SPD_D[t]) begin
        g = q[t];
      end else begin
        g = '0;
      end
      gc[t] = (g < strength[t]) ? g : strength[t];

      q_up = q[t] + MW'(fdsc_pkg::RISE_Q[t]);
      r_up = r[t] + RW'(fdsc_pkg::RISE_R[t]);
      if (r_up >= RW'(fdsc_pkg::RISE_WD[t])) begin
        r_up = r_up - RW'(fdsc_pkg::RISE_WD[t]);
        q_up = q_up + MW'(1);
      end
      q_dn = q[t] - MW'(fdsc_pkg::FALL_Q[t]);
      r_dn = r[t] - RW'(fdsc_pkg::FALL_R[t]);
      if (r_dn < 0) begin
        r_dn = r_dn + RW'(fdsc_pkg::FALL_WD[t]);
        q_dn = q_dn - MW'(1);
      end

      if (xn <= fdsc_pkg::SPD_A[t]) begin
        q_next[t] = '0;
        r_next[t] = '0;
      end else if (xn < fdsc_pkg::SPD_B[t]) begin
        q_next[t] = q_up;
        r_next[t] = r_up;
      end else if (xn <= fdsc_pkg::SPD_C[t]) begin
        q_next[t] = MW'(fdsc_pkg::ONE);
        r_next[t] = '0;
      end else if (xn < fdsc_pkg::SPD_D[t]) begin
        q_next[t] = q_dn;
        r_next[t] = r_dn;
      end else begin
        q_next[t] = q[t];
        r_next[t] = r[t];
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        q[t] <= '0;
        r[t] <= '0;
      end else if (run) begin
        q[t] <= q_next[t];
        r[t] <= r_next[t];
      end
    end
  end

  always_comb begin
    agg = '0;
    for (int t = 0; t < N; t++) begin
      if (gc[t] > agg) begin
        agg = gc[t];
      end
    end
  end

  assign prod = $signed({1'b0, agg_r}) * xa_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      agg_v  <= 1'b0;
      last_v <= 1'b0;
      done   <= 1'b0;
    end else begin
      agg_v  <= run;
      last_v <= run && (x == XW'(fdsc_pkg::SWEEP_HI - 1));
      done   <= agg_v && last_v;
      if (start) begin
        run <= 1'b1;
      end else if (run && x == XW'(fdsc_pkg::SWEEP_HI - 1)) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    agg_r <= agg;
    xa_r  <= x;
    if (start) begin
      x      <= XW'(fdsc_pkg::SWEEP_LO);
      area   <= '0;
      moment <= '0;
    end else begin
      if (run) begin
        x <= xn;
      end
      if (agg_v) begin
        area   <= area + fdsc_pkg::AREA_BITS'(agg_r);
        moment <= moment + fdsc_pkg::MOM_BITS'(prod);
      end
    end
  end

  assign res.done   = done;
  assign res.area   = area;
  assign res.moment = moment;

endmodule

// ===== src/fdsc_div.sv =====
// Restoring divider, one quotient bit per cycle, for the centroid quotient.
// Depends on fdsc_pkg.
`timescale 1ns / 1ps
module fdsc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [fdsc_pkg::DIVN_BITS-1:0] dividend,
  input  logic [fdsc_pkg::DIVD_BITS-1:0] divisor,
  output fdsc_pkg::div_res_t             res
);
  localparam int NB = fdsc_pkg::DIVN_BITS;
  localparam int DB = fdsc_pkg::DIVD_BITS;
  localparam int CB = $clog2(NB + 1);

  logic [NB-1:0] num;
  logic [DB:0]   rem;
  logic [DB-1:0] den;
  logic [CB-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DB:0]   shifted;
  logic          fits;

  assign shifted = {rem[DB-1:0], num[NB-1]};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CB'(NB - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      rem <= fits ? (shifted - {1'b0, den}) : shifted;
      num <= {num[NB-2:0], fits};
      cnt <= cnt + CB'(1);
    end
  end

  assign res.done = done;
  assign res.quot = num;

endmodule

// ===== src/fuzzy_distance_to_speed_controller.sv =====
// Top level: clamping, fuzzification, rule sequencer, sweep and divider control, output register.
// Depends on fdsc_pkg, fdsc_sweep and fdsc_div.
//
// Usage:
//   Input channel (in_valid/in_ready) takes three distance readings and a side select.
//   in_ready is high only while the sequencer is idle; one request is worked at a time.
//   Output channel (out_valid/out_ready) returns motor_speed and no_rule_fired from an
//   output register, so a new request can be taken while a result waits for the receiver.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   index 0 is the input floor, index 1 the input ceiling, other indexes are dropped.
//   A request passes the fuzzify step, 64 rules (one rule per cycle through the shared
//   min/max compare), 350 sweep points at one per cycle plus the sweep pipeline, the
//   bit-serial divider (29 quotient bits) and the load of the output register. When no
//   rule fired the divider is skipped. A new request is taken only once the sequencer
//   has passed its result to the output register and returned to idle.
//   Reset (rst, synchronous) returns the sequencer to idle, clears out_valid and loads the
//   clamp registers with 0 and 255. A stalled receiver holds the result in place; the
//   next result waits in the done state until the output register is free.
`timescale 1ns / 1ps
module fuzzy_distance_to_speed_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [15:0]                dist_left,
  input  logic signed [15:0]                dist_mid,
  input  logic signed [15:0]                dist_right,
  input  logic                              side_is_left,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [8:0]                 motor_speed,
  output logic                              no_rule_fired,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fdsc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [15:0]                       cfg_data
);
  localparam int ND = fdsc_pkg::N_DIST_TERMS;
  localparam int NS = fdsc_pkg::N_SPEED_TERMS;
  localparam int TB = fdsc_pkg::TERM_BITS;
  localparam int RB = fdsc_pkg::RULE_BITS;

  fdsc_pkg::st_t state, state_next;

  logic signed [15:0] input_floor;
  logic signed [15:0] input_ceiling;
  logic signed [15:0] dl, dm, dr;
  logic               side;
  fdsc_pkg::memb_t    ml [ND];
  fdsc_pkg::memb_t    mm [ND];
  fdsc_pkg::memb_t    mr [ND];
  fdsc_pkg::memb_t    strength [NS];
  logic [RB-1:0]      rule_cnt;

  fdsc_pkg::memb_t    s_min;
  fdsc_pkg::memb_t    mi, mj, mk;
  logic [fdsc_pkg::SPD_IDX_BITS-1:0] rule_t;

  logic sweep_start;
  logic div_start;
  logic load_out;
  logic rule_last;
  fdsc_pkg::sweep_res_t sres;
  fdsc_pkg::div_res_t   dres;

  logic                                  neg;
  logic [fdsc_pkg::MOM_BITS-1:0]         m_abs;
  logic [fdsc_pkg::DIVN_BITS-1:0]        dividend;
  logic [fdsc_pkg::DIVD_BITS-1:0]        divisor;
  logic signed [8:0]                     res_speed;
  logic                                  res_flag;
  logic [8:0]                            q9;

  function automatic logic signed [15:0] clamp_in(input logic signed [15:0] v,
                                                   input logic signed [15:0] lo,
                                                   input logic signed [15:0] hi);
    logic signed [15:0] c;
    c = (v > hi) ? hi : v;
    c = (c < lo) ? lo : c;
    return c;
  endfunction

  assign cfg_ready = 1'b1;
  assign rule_last = rule_cnt == {RB{1'b1}};

  assign mi     = ml[rule_cnt[3*TB-1:2*TB]];
  assign mj     = mm[rule_cnt[2*TB-1:TB]];
  assign mk     = mr[rule_cnt[TB-1:0]];
  assign rule_t = side ? fdsc_pkg::RULE_LEFT[rule_cnt] : fdsc_pkg::RULE_RIGHT[rule_cnt];

  always_comb begin
    s_min = (mi < mj) ? mi : mj;
    s_min = (mk < s_min) ? mk : s_min;
  end

  assign neg      = sres.moment < 0;
  assign m_abs    = neg ? fdsc_pkg::MOM_BITS'(-sres.moment)
                        : fdsc_pkg::MOM_BITS'(sres.moment);
  assign dividend = fdsc_pkg::DIVN_BITS'({m_abs, 1'b0})
                  + fdsc_pkg::DIVN_BITS'(sres.area);
  assign divisor  = {sres.area, 1'b0};
  assign q9       = dres.quot[8:0];

  always_comb begin
    state_next = state;
    case (state)
      fdsc_pkg::S_IDLE:     if (in_valid) state_next = fdsc_pkg::S_FUZZ;
      fdsc_pkg::S_FUZZ:     state_next = fdsc_pkg::S_RULE;
      fdsc_pkg::S_RULE:     if (rule_last) state_next = fdsc_pkg::S_SWEEP_GO;
      fdsc_pkg::S_SWEEP_GO: state_next = fdsc_pkg::S_SWEEP;
      fdsc_pkg::S_SWEEP: begin
        if (sres.done) begin
          state_next = (sres.area == '0) ? fdsc_pkg::S_DONE : fdsc_pkg::S_DIV_GO;
        end
      end
      fdsc_pkg::S_DIV_GO:   state_next = fdsc_pkg::S_DIV;
      fdsc_pkg::S_DIV:      if (dres.done) state_next = fdsc_pkg::S_DONE;
      fdsc_pkg::S_DONE:     if (!out_valid || out_ready) state_next = fdsc_pkg::S_IDLE;
      default:              state_next = fdsc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    sweep_start = 1'b0;
    div_start   = 1'b0;
    load_out    = 1'b0;
    case (state)
      fdsc_pkg::S_IDLE:     in_ready = 1'b1;
      fdsc_pkg::S_SWEEP_GO: sweep_start = 1'b1;
      fdsc_pkg::S_DIV_GO:   div_start = 1'b1;
      fdsc_pkg::S_DONE:     load_out = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= fdsc_pkg::S_IDLE;
      out_valid     <= 1'b0;
      input_floor   <= fdsc_pkg::FLOOR_RESET;
      input_ceiling <= fdsc_pkg::CEILING_RESET;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_index == fdsc_pkg::REG_FLOOR) begin
        input_floor <= cfg_data;
      end
      if (cfg_valid && cfg_index == fdsc_pkg::REG_CEILING) begin
        input_ceiling <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dl   <= clamp_in(dist_left, input_floor, input_ceiling);
      dm   <= clamp_in(dist_mid, input_floor, input_ceiling);
      dr   <= clamp_in(dist_right, input_floor, input_ceiling);
      side <= side_is_left;
    end
    if (state == fdsc_pkg::S_FUZZ) begin
      for (int t = 0; t < ND; t++) begin
        ml[t] <= fdsc_pkg::dist_grade(t, dl);
        mm[t] <= fdsc_pkg::dist_grade(t, dm);
        mr[t] <= fdsc_pkg::dist_grade(t, dr);
      end
      for (int t = 0; t < NS; t++) begin
        strength[t] <= '0;
      end
      rule_cnt <= '0;
    end
    if (state == fdsc_pkg::S_RULE) begin
      if (s_min > strength[rule_t]) begin
        strength[rule_t] <= s_min;
      end
      rule_cnt <= rule_cnt + RB'(1);
    end
    if (state == fdsc_pkg::S_SWEEP && sres.done && sres.area == '0) begin
      res_speed <= '0;
      res_flag  <= 1'b1;
    end
    if (dres.done) begin
      res_speed <= neg ? $signed(-q9) : $signed(q9);
      res_flag  <= 1'b0;
    end
    if (load_out) begin
      motor_speed   <= res_speed;
      no_rule_fired <= res_flag;
    end
  end

  fdsc_sweep u_sweep (
    .clk      (clk),
    .rst      (rst),
    .start    (sweep_start),
    .strength (strength),
    .res      (sres)
  );

  fdsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .res      (dres)
  );

endmodule

// ===== sim/fuzzy_distance_to_speed_controller_test.sv =====
// Self-checking testbench for the fuzzy distance-to-speed controller: directed and random
// requests, clamp register writes between phases, and a speed predictor checked per result.
// Depends on fdsc_pkg and fuzzy_distance_to_speed_controller.
`timescale 1ns / 1ps
module fuzzy_distance_to_speed_controller_test;

  typedef struct {
    logic signed [15:0] dl, dm, dr;
    logic               side;
  } req_t;

  typedef struct {
    logic signed [8:0] speed;
    logic              empty;
  } speed_t;

  typedef struct {
    req_t  r;
    bit    known;
    speed_t s;
  } row_t;

  localparam int WATCHDOG = 20000;
  localparam logic [fdsc_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, out_ready = 1'b0, cfg_valid = 1'b0;
  logic in_ready, out_valid, cfg_ready, no_rule_fired, side_is_left = 1'b0;
  logic signed [15:0] dist_left = '0, dist_mid = '0, dist_right = '0;
  logic signed [8:0] motor_speed;
  logic [fdsc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  fuzzy_distance_to_speed_controller u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int clamp_lo = 0, clamp_hi = 255;
  speed_t speeds_due[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit long_stall = 1'b0;

  function automatic longint trapezoid(int a, int b, int c, int d, int x);
    if (x <= a || x >= d) return 0;
    if (x < b) return (longint'(x - a) * 256) / (b - a);
    if (x <= c) return 256;
    return (longint'(d - x) * 256) / (d - c);
  endfunction

  function automatic int clamp_reading(int x);
    if (x > clamp_hi) x = clamp_hi;
    if (x < clamp_lo) x = clamp_lo;
    return x;
  endfunction

  function automatic speed_t predict_speed(req_t r);
    int d[3];
    longint g[3][4];
    longint str[6];
    longint s, agg, gt, area, mom, q;
    int t;
    speed_t res;
    int da[4] = '{-15, 10, 35, 60};
    int db[4] = '{0, 25, 50, 75};
    int dc[4] = '{10, 35, 60, 255};
    int dd[4] = '{25, 50, 75, 270};
    int sa[6] = '{-200, -135, -115, 40, 50, 65};
    int sb[6] = '{-175, -115, -85, 45, 55, 95};
    int sc[6] = '{-135, -105, -70, 50, 65, 125};
    int sd[6] = '{-105, -85, -60, 55, 95, 150};
    int tl[64] = '{1,3,5,4, 1,3,5,4, 1,3,5,4, 1,3,5,4,
                   4,1,4,1, 4,1,4,5, 1,1,1,5, 4,1,5,5,
                   1,1,3,1, 1,2,3,5, 1,2,3,5, 1,1,4,5,
                   0,1,1,1, 1,3,4,3, 1,3,4,4, 1,3,4,5};
    int tr[64] = '{4,2,3,1, 4,2,3,1, 4,2,3,1, 4,2,3,1,
                   1,4,1,4, 1,4,1,3, 1,4,4,3, 1,4,3,3,
                   4,4,5,4, 4,3,5,3, 4,3,5,4, 4,4,5,4,
                   4,4,4,4, 4,5,5,5, 4,5,5,5, 4,5,5,5};
    d[0] = clamp_reading(r.dl);
    d[1] = clamp_reading(r.dm);
    d[2] = clamp_reading(r.dr);
    for (int c = 0; c < 3; c++)
      for (int i = 0; i < 4; i++) g[c][i] = trapezoid(da[i], db[i], dc[i], dd[i], d[c]);
    for (int i = 0; i < 6; i++) str[i] = 0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        for (int k = 0; k < 4; k++) begin
          t = r.side ? tl[i*16 + j*4 + k] : tr[i*16 + j*4 + k];
          s = g[0][i];
          if (g[1][j] < s) s = g[1][j];
          if (g[2][k] < s) s = g[2][k];
          if (s > str[t]) str[t] = s;
        end
    area = 0;
    mom = 0;
    for (int x = -200; x < 150; x++) begin
      agg = 0;
      for (int i = 0; i < 6; i++) begin
        gt = trapezoid(sa[i], sb[i], sc[i], sd[i], x);
        if (gt > str[i]) gt = str[i];
        if (gt > agg) agg = gt;
      end
      area += agg;
      mom += agg * x;
    end
    if (area == 0) begin
      res.speed = '0;
      res.empty = 1'b1;
    end else begin
      if (mom >= 0) q = (2 * mom + area) / (2 * area);
      else q = -((2 * (-mom) + area) / (2 * area));
      res.speed = 9'(q);
      res.empty = 1'b0;
    end
    return res;
  endfunction

  // Receiver: check at the rising edge, stall on its own pattern.
  always @(posedge clk) begin
    speed_t e;
    if (!rst && out_valid && out_ready) begin
      if (speeds_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result speed=%0d", motor_speed);
      end else begin
        e = speeds_due.pop_front();
        if (e.speed !== motor_speed || e.empty !== no_rule_fired) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected speed=%0d empty=%0b, got speed=%0d empty=%0b",
                     e.speed, e.empty, motor_speed, no_rule_fired);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (long_stall) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Hold the receiver off long enough for the block to fill and stall its input.
  initial begin
    wait (!rst);
    repeat (3000) @(posedge clk);
    long_stall = 1'b1;
    repeat (2500) @(posedge clk);
    long_stall = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("fuzzy_distance_to_speed_controller_test NOT OK");
      $finish;
    end
  end

  task automatic send_request(req_t r);
    dist_left <= r.dl;
    dist_mid <= r.dm;
    dist_right <= r.dr;
    side_is_left <= r.side;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    speeds_due.push_back(predict_speed(r));
    @(negedge clk);
  endtask

  task automatic send_row(row_t w);
    dist_left <= w.r.dl;
    dist_mid <= w.r.dm;
    dist_right <= w.r.dr;
    side_is_left <= w.r.side;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (w.known) speeds_due.push_back(w.s);
    else speeds_due.push_back(predict_speed(w.r));
    @(negedge clk);
  endtask

  task automatic write_clamp(logic [fdsc_pkg::CFG_IDX_BITS-1:0] idx, int v);
    cfg_index <= idx;
    cfg_data <= 16'(v);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == fdsc_pkg::REG_FLOOR) clamp_lo = int'($signed(16'(v)));
    else if (idx == fdsc_pkg::REG_CEILING) clamp_hi = int'($signed(16'(v)));
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    hold_off = 1'b1;
    wait (speeds_due.size() == 0);
    repeat (500) @(negedge clk);
    hold_off = 1'b0;
  endtask

  function automatic int pick_reading();
    case ($urandom_range(0, 5))
      0: return int'($signed(16'($urandom())));
      1: return $urandom_range(0, 300) - 20;
      2: return $urandom_range(0, 1) ? 32767 : -32768;
      default: return $urandom_range(0, 90) - 15;
    endcase
  endfunction

  task automatic random_phase(int n);
    req_t r;
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 8);
      for (int i = 0; i < burst && n > 0; i++, n--) begin
        r.dl = 16'(pick_reading());
        r.dm = 16'(pick_reading());
        r.dr = 16'(pick_reading());
        r.side = $urandom_range(0, 1);
        send_request(r);
      end
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 600)) @(negedge clk);
      end
    end
  endtask

  row_t rows[$];

  function automatic row_t mk(int a, int b, int c, bit sd, bit k, int sp, bit em);
    row_t w;
    w.r.dl = 16'(a);
    w.r.dm = 16'(b);
    w.r.dr = 16'(c);
    w.r.side = sd;
    w.known = k;
    w.s.speed = 9'(sp);
    w.s.empty = em;
    return w;
  endfunction

  initial begin
    rows.push_back(mk(-32768, -32768, -32768, 1, 0, 0, 0));
    rows.push_back(mk(32767, 32767, 32767, 0, 0, 0, 0));
    rows.push_back(mk(32767, 32767, 32767, 1, 0, 0, 0));
    rows.push_back(mk(0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(5, 30, 55, 1, 0, 0, 0));
    rows.push_back(mk(5, 30, 55, 0, 0, 0, 0));
    rows.push_back(mk(17, 42, 67, 1, 0, 0, 0));
    rows.push_back(mk(100, 12, 62, 0, 0, 0, 0));
    rows.push_back(mk(-1, 256, 300, 1, 0, 0, 0));
    rows.push_back(mk(-21846, 21845, 10, 0, 0, 0, 0));
    rows.push_back(mk(25, 50, 75, 1, 0, 0, 0));
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < rows.size(); i++) begin
      send_row(rows[i]);
      if (i % 3 == 2) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    drain();
    // Readings far outside the grades: the clamp leaves every term empty.
    write_clamp(fdsc_pkg::REG_FLOOR, 300);
    write_clamp(fdsc_pkg::REG_CEILING, 400);
    write_clamp(REG_SPARE, 5);
    rows.delete();
    rows.push_back(mk(0, 0, 0, 1, 1, 0, 1));
    rows.push_back(mk(-32768, 32767, 280, 0, 1, 0, 1));
    foreach (rows[i]) send_row(rows[i]);
    random_phase(20);
    drain();
    write_clamp(fdsc_pkg::REG_FLOOR, 50);
    write_clamp(fdsc_pkg::REG_CEILING, 20);
    random_phase(20);
    drain();
    write_clamp(fdsc_pkg::REG_FLOOR, -32768);
    write_clamp(fdsc_pkg::REG_CEILING, 32767);
    random_phase(300);
    drain();
    write_clamp(fdsc_pkg::REG_FLOOR, -20);
    write_clamp(fdsc_pkg::REG_CEILING, 90);
    random_phase(700);
    drain();
    write_clamp(fdsc_pkg::REG_FLOOR, 0);
    write_clamp(fdsc_pkg::REG_CEILING, 255);
    random_phase(350);
    drain();
    if (mismatches == 0) $display("fuzzy_distance_to_speed_controller_test OK");
    else $display("fuzzy_distance_to_speed_controller_test NOT OK");
    $finish;
  end
endmodule
